@@ hdl/touching_rectangle_fragment_tracker_assert.svh @@
// assertion macros for the tracker rtl
`ifndef TOUCHING_RECTANGLE_FRAGMENT_TRACKER_ASSERT_SVH
`define TOUCHING_RECTANGLE_FRAGMENT_TRACKER_ASSERT_SVH

// a condition that holds at every edge outside reset
`define TRFT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// an antecedent that implies a consequent in the same cycle
`define TRFT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hdl/trft_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trft_pkg
// shared constants and types of the touching rectangle fragment tracker
// ---------------------------------------------------------------------------
package trft_pkg;
	localparam int MAX_BLOCKS = 256;
	localparam int NUM_GROUPS = 15;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int GRP_W      = 4;
	localparam int OUT_W      = 9;

	// one stored rectangle as it moves along the cell row
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic [GRP_W-1:0]      grp;
		logic [IDX_W-1:0]      label;
	} entry_t;
endpackage

@@ hdl/trft_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trft_if
// valid/ready channels for input words and result words
// ---------------------------------------------------------------------------
interface trft_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] rect_width;
	logic [15:0] rect_height;
	logic [3:0]  cluster_group;
	logic [3:0]  rect_group;
	modport source (output valid, cmd, pos_x, pos_y, rect_width, rect_height,
		cluster_group, rect_group, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, rect_width, rect_height,
		cluster_group, rect_group, output ready);
endinterface

interface trft_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] excess_frags;
	logic [8:0] clustered_blocks;
	logic       store_full;
	modport source (output valid, excess_frags, clustered_blocks, store_full,
		input ready);
	modport sink (input valid, excess_frags, clustered_blocks, store_full,
		output ready);
endinterface

@@ hdl/trft_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trft_cell
// one storage cell of the rotating rectangle row
// ---------------------------------------------------------------------------
module trft_cell import trft_pkg::*; (
	input  logic   clk,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);
	entry_t ent_q;

	// take the neighbor's entry on every shift
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;
endmodule

@@ hdl/touching_rectangle_fragment_tracker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touching_rectangle_fragment_tracker
// groups touching rectangles into fragments, reports fragment counts
// ---------------------------------------------------------------------------
// sequence: an added grouped block takes two full rotations of the cell row
//   past one touch comparator (WALK1 marks, WALK2 relabels and inserts); clear,
//   ungrouped and full-store words go straight from IDLE to DONE
// throughput: one word at a time, next word taken once the result is queued
// reset: counts, group table, hit marks and config cleared at once; stored
//   entries are undefined until written and are never read before that
module touching_rectangle_fragment_tracker import trft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_data,
	trft_in_if.sink    in_ch,
	trft_out_if.source out_ch
);
	`include "touching_rectangle_fragment_tracker_assert.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK1 = 2'd1;
	localparam logic [1:0] ST_WALK2 = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_BLOCKS - 1);

	logic [1:0]            state_q;
	logic                  use_rect_q;
	logic [COUNT_W-1:0]    count_q;
	logic [OUT_W-1:0]      extra_q;
	logic [OUT_W-1:0]      gf_q [NUM_GROUPS+1];
	logic [MAX_BLOCKS-1:0] hit_q;
	logic [COUNT_W-1:0]    touched_q;
	logic [IDX_W-1:0]      min_lab_q;
	logic [IDX_W-1:0]      pos_q;
	logic [GRP_W-1:0]      g_q;
	entry_t                new_q;
	logic                  full_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_extra_q;
	logic [OUT_W-1:0]      out_count_q;
	logic                  out_full_q;

	entry_t cell_q   [MAX_BLOCKS];
	entry_t head_mod;
	logic   shift;

	// the row rotates toward cell 0, the edited head re-enters at the tail
	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_row
		entry_t nb;
		if (k == MAX_BLOCKS - 1) begin : g_tail
			assign nb = head_mod;
		end else begin : g_mid
			assign nb = cell_q[k+1];
		end
		trft_cell u_cell (.clk(clk), .shift(shift), .d(nb), .q(cell_q[k]));
	end

	assign shift = (state_q == ST_WALK1) || (state_q == ST_WALK2);

	// touch test on the head entry, closed intervals at full precision
	entry_t              head;
	logic                head_live;
	logic                touch;
	logic                grp_hit;
	logic                lab_hit;
	logic [COUNT_W-1:0]  me;
	logic                at_me;
	assign head      = cell_q[0];
	assign head_live = {1'b0, pos_q} < count_q;
	assign touch = ({1'b0, new_q.x} <= {1'b0, head.x} + {1'b0, head.w}) &&
		({1'b0, head.x} <= {1'b0, new_q.x} + {1'b0, new_q.w}) &&
		({1'b0, new_q.y} <= {1'b0, head.y} + {1'b0, head.h}) &&
		({1'b0, head.y} <= {1'b0, new_q.y} + {1'b0, new_q.h});
	assign grp_hit = head_live && (head.grp == g_q);
	assign lab_hit = hit_q[head.label];
	assign me      = count_q;
	assign at_me   = {1'b0, pos_q} == me;

	// head edit: relabel merged fragments, drop the new block in its slot
	always_comb begin
		head_mod = head;
		if (state_q == ST_WALK2) begin
			if (grp_hit && lab_hit && (touched_q > COUNT_W'(1))) begin
				head_mod.label = IDX_W'(me);
			end
			if (at_me) begin
				head_mod = new_q;
				head_mod.label = (touched_q == COUNT_W'(1)) ? min_lab_q : IDX_W'(me);
			end
		end
	end

	// group id chosen by the config register
	logic [GRP_W-1:0] g_sel;
	assign g_sel = use_rect_q ? in_ch.rect_group : in_ch.cluster_group;

	assign in_ch.ready = (state_q == ST_IDLE);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_rect_q <= 1'b0;
		end else if (cfg_we) begin
			use_rect_q <= cfg_data;
		end
	end

	// control and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			extra_q   <= '0;
			hit_q     <= '0;
			touched_q <= '0;
			pos_q     <= '0;
			full_q    <= 1'b0;
			for (int i = 0; i <= NUM_GROUPS; i++) gf_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						full_q <= 1'b0;
						state_q <= ST_DONE;
						if (!in_ch.cmd) begin
							count_q <= '0;
							extra_q <= '0;
							for (int i = 0; i <= NUM_GROUPS; i++) gf_q[i] <= '0;
						end else if (g_sel == '0 || 32'(g_sel) > NUM_GROUPS) begin
							full_q <= 1'b0;
						end else if (count_q >= COUNT_W'(MAX_BLOCKS)) begin
							full_q <= 1'b1;
						end else begin
							hit_q     <= '0;
							touched_q <= '0;
							pos_q     <= '0;
							state_q   <= ST_WALK1;
						end
					end
				end
				ST_WALK1: begin
					// mark each distinct touched fragment once
					if (grp_hit && touch && !lab_hit) begin
						hit_q[head.label] <= 1'b1;
						touched_q <= touched_q + COUNT_W'(1);
					end
					pos_q <= pos_q + IDX_W'(1);
					if (pos_q == LAST_POS) state_q <= ST_WALK2;
				end
				ST_WALK2: begin
					pos_q <= pos_q + IDX_W'(1);
					if (pos_q == LAST_POS) begin
						count_q <= count_q + COUNT_W'(1);
						state_q <= ST_DONE;
						if (touched_q == '0) begin
							if (gf_q[g_q] != '0) extra_q <= extra_q + OUT_W'(1);
							gf_q[g_q] <= gf_q[g_q] + OUT_W'(1);
						end else begin
							gf_q[g_q] <= gf_q[g_q] - OUT_W'(touched_q - COUNT_W'(1));
							extra_q   <= extra_q - OUT_W'(touched_q - COUNT_W'(1));
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input word capture, and lowest touched label kept for the single-fragment join
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			g_q <= g_sel;
			new_q.x <= in_ch.pos_x;
			new_q.y <= in_ch.pos_y;
			new_q.w <= in_ch.rect_width;
			new_q.h <= in_ch.rect_height;
			new_q.grp <= g_sel;
			new_q.label <= '0;
		end
		if (state_q == ST_WALK1 && grp_hit && touch && !lab_hit &&
				(touched_q == '0 || head.label < min_lab_q)) begin
			min_lab_q <= head.label;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_extra_q <= extra_q;
			out_count_q <= OUT_W'(count_q);
			out_full_q  <= full_q;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.excess_frags     = out_extra_q;
	assign out_ch.clustered_blocks = out_count_q;
	assign out_ch.store_full       = out_full_q;

	// checks
	`TRFT_ASSERT_ALWAYS(a_count_bound, count_q <= COUNT_W'(MAX_BLOCKS), "store count overflow")
	`TRFT_ASSERT_IMPL(a_touch_bound, state_q == ST_WALK2, touched_q <= count_q, "touched exceeds stored")
	`TRFT_ASSERT_IMPL(a_walk_shift, state_q == ST_WALK1 || state_q == ST_WALK2, !in_ch.ready, "word taken mid walk")
endmodule

@@ bench/trft_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trft_checker
// Watches the input and result channels of the fragment tracker. It keeps
// its own store of grouped rectangles and fragment labels, works out the
// result word for every accepted input word, and compares each result word
// field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module trft_checker import trft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_data,
	trft_in_if   in_ch,
	trft_out_if  out_ch,
	output int   errors,
	output int   pending
);
	typedef struct {
		logic [OUT_W-1:0] excess_frags;
		logic [OUT_W-1:0] clustered_blocks;
		logic             store_full;
	} tally_t;

	// shadow copy of the block state
	logic                  sel_rect;
	logic [COORD_BITS-1:0] rx [MAX_BLOCKS];
	logic [COORD_BITS-1:0] ry [MAX_BLOCKS];
	logic [COORD_BITS-1:0] rw [MAX_BLOCKS];
	logic [COORD_BITS-1:0] rh [MAX_BLOCKS];
	logic [GRP_W-1:0]      rgrp [MAX_BLOCKS];
	int                    rlabel [MAX_BLOCKS];
	int                    n_stored;
	int                    frag_count [NUM_GROUPS+1];
	int                    extra_sum;
	tally_t                tally_q [$];

	// closed intervals meet, sums kept at full width
	function automatic bit spans_meet(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] al,
		logic [COORD_BITS-1:0] b, logic [COORD_BITS-1:0] bl);
		logic [COORD_BITS:0] ae, be;
		ae = {1'b0, a} + {1'b0, al};
		be = {1'b0, b} + {1'b0, bl};
		return ({1'b0, a} <= be) && ({1'b0, b} <= ae);
	endfunction

	// apply one word to the shadow state and return its tally
	function automatic tally_t track_rectangle(logic cmd, logic [15:0] x, logic [15:0] y,
		logic [15:0] w, logic [15:0] h, logic [3:0] cg, logic [3:0] rg);
		tally_t t;
		int     g, hits, me, first_lab;
		bit     hit [MAX_BLOCKS];
		t.store_full = 1'b0;
		if (!cmd) begin
			n_stored = 0;
			extra_sum = 0;
			foreach (frag_count[i]) frag_count[i] = 0;
		end else begin
			g = int'(sel_rect ? rg : cg);
			if (g != 0 && g <= NUM_GROUPS) begin
				if (n_stored >= MAX_BLOCKS) begin
					t.store_full = 1'b1;
				end else begin
					me = n_stored;
					hits = 0;
					first_lab = MAX_BLOCKS;
					foreach (hit[i]) hit[i] = 0;
					// mark the distinct fragments touched
					for (int k = 0; k < n_stored; k++) begin
						if (rgrp[k] == g && spans_meet(x, w, rx[k], rw[k]) &&
							spans_meet(y, h, ry[k], rh[k]) && !hit[rlabel[k]]) begin
							hit[rlabel[k]] = 1;
							hits++;
							if (rlabel[k] < first_lab) first_lab = rlabel[k];
						end
					end
					// merge touched fragments onto the new block
					if (hits > 1)
						for (int k = 0; k < n_stored; k++)
							if (rgrp[k] == g && hit[rlabel[k]]) rlabel[k] = me;
					rx[me] = x;
					ry[me] = y;
					rw[me] = w;
					rh[me] = h;
					rgrp[me] = GRP_W'(g);
					rlabel[me] = (hits == 1) ? first_lab : me;
					n_stored++;
					if (hits == 0) begin
						if (frag_count[g] > 0) extra_sum++;
						frag_count[g]++;
					end else begin
						frag_count[g] -= hits - 1;
						extra_sum -= hits - 1;
					end
				end
			end
		end
		t.excess_frags = extra_sum[OUT_W-1:0];
		t.clustered_blocks = n_stored[OUT_W-1:0];
		return t;
	endfunction

	assign pending = tally_q.size();

	// predict on accepted input, compare on accepted result
	always @(posedge clk or negedge arst_n) begin
		tally_t want;
		tally_t next_t;
		if (!arst_n) begin
			sel_rect <= 1'b0;
			n_stored = 0;
			extra_sum = 0;
			foreach (frag_count[i]) frag_count[i] = 0;
			errors = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				next_t = track_rectangle(in_ch.cmd, in_ch.pos_x, in_ch.pos_y,
					in_ch.rect_width, in_ch.rect_height, in_ch.cluster_group,
					in_ch.rect_group);
				tally_q = {tally_q, next_t};
			end
			if (out_ch.valid && out_ch.ready) begin
				if (tally_q.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = tally_q.pop_front();
					if (out_ch.excess_frags !== want.excess_frags) begin
						$error("excess_frags: expected %0d, got %0d",
							want.excess_frags, out_ch.excess_frags);
						errors++;
					end
					if (out_ch.clustered_blocks !== want.clustered_blocks) begin
						$error("clustered_blocks: expected %0d, got %0d",
							want.clustered_blocks, out_ch.clustered_blocks);
						errors++;
					end
					if (out_ch.store_full !== want.store_full) begin
						$error("store_full: expected %0d, got %0d",
							want.store_full, out_ch.store_full);
						errors++;
					end
				end
			end
			if (cfg_we) sel_rect <= cfg_data;
		end
	end
endmodule

@@ bench/tb_touching_rectangle_fragment_tracker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_touching_rectangle_fragment_tracker
// Drives rectangle words into the fragment tracker: a directed set of edge
// touches, merges, extremes and clears, then random phases of clustered
// rectangles, including one run that fills the store. Both channels stall at
// random. The checker beside the block predicts and compares every word.
// ---------------------------------------------------------------------------
module tb_touching_rectangle_fragment_tracker;
	import trft_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_data = 1'b0;
	logic no_idle = 1'b0;
	int   words_in = 0;
	int   words_out = 0;
	int   quiet_cycles = 0;
	int   errors, pending;

	trft_in_if  in_ch ();
	trft_out_if out_ch ();

	touching_rectangle_fragment_tracker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	trft_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	always #2 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = 1'b1;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.rect_width = '0;
		in_ch.rect_height = '0;
		in_ch.cluster_group = '0;
		in_ch.rect_group = '0;
		out_ch.ready = 1'b0;
	end

	// result side stalls at random
	always @(posedge clk)
		out_ch.ready <= no_idle || ($urandom_range(99) >= 31);

	// word counts and watchdog
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) words_in <= words_in + 1;
		if (out_ch.valid && out_ch.ready) words_out <= words_out + 1;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("touching_rectangle_fragment_tracker: mismatch");
			$finish;
		end
	end

	// one word through the handshake, then at times a random gap
	task automatic send_word(logic cmd, logic [15:0] x, logic [15:0] y, logic [15:0] w,
		logic [15:0] h, logic [3:0] cg, logic [3:0] rg);
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.pos_x <= x;
		in_ch.pos_y <= y;
		in_ch.rect_width <= w;
		in_ch.rect_height <= h;
		in_ch.cluster_group <= cg;
		in_ch.rect_group <= rg;
		do @(posedge clk); while (!in_ch.ready);
		if (!no_idle && $urandom_range(99) < 31) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// register write once every result is back
	task automatic write_select(logic v);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_out != words_in) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random rectangle, mostly small and crowded so that touches are common
	task automatic random_rect(logic [3:0] grp, logic sel);
		logic [15:0] x, y, w, h;
		logic [3:0]  cg, rg;
		if ($urandom_range(19) == 0) begin
			x = 16'($urandom);
			y = 16'($urandom);
			w = 16'($urandom);
			h = 16'($urandom);
		end else begin
			x = 16'($urandom_range(300));
			y = 16'($urandom_range(300));
			w = 16'($urandom_range(40));
			h = 16'($urandom_range(40));
		end
		cg = 4'($urandom);
		rg = 4'($urandom);
		if (sel) rg = grp; else cg = grp;
		send_word(1'b1, x, y, w, h, cg, rg);
	endtask

	task automatic random_phase(int count, bit fill);
		int  r;
		logic sel;
		sel = cfg_data;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (!fill && r < 3)
				send_word(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 4'($urandom), 4'($urandom));
			else if (!fill && r < 13)
				random_rect(4'd0, sel);
			else if (r < 80)
				random_rect(4'($urandom_range(1, 3)), sel);
			else
				random_rect(4'($urandom_range(1, 15)), sel);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clear, ungrouped, extremes, edge touch, merge
		send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF);
		send_word(1'b1, 16'd5, 16'd5, 16'd5, 16'd5, 4'd0, 4'd7);
		send_word(1'b1, 16'd0, 16'd0, 16'd10, 16'd10, 4'd1, 4'd0);
		send_word(1'b1, 16'd100, 16'd0, 16'd10, 16'd10, 4'd1, 4'd2);
		send_word(1'b1, 16'd10, 16'd10, 16'd90, 16'd0, 4'd1, 4'd3);
		send_word(1'b1, 16'd200, 16'd200, 16'd0, 16'd0, 4'd1, 4'd0);
		send_word(1'b1, 16'd200, 16'd200, 16'd0, 16'd0, 4'd2, 4'd0);
		send_word(1'b1, 16'd201, 16'd200, 16'd0, 16'd0, 4'd2, 4'd0);
		send_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'h0);
		send_word(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 4'hF, 4'h0);
		send_word(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'hF, 4'h0);
		send_word(1'b1, 16'd202, 16'd200, 16'd0, 16'd0, 4'd2, 4'd0);
		send_word(1'b1, 16'd201, 16'd200, 16'd1, 16'd0, 4'd2, 4'd0);
		send_word(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
		send_word(1'b1, 16'd3, 16'd3, 16'd3, 16'd3, 4'd1, 4'd0);
		write_select(1'b1);
		send_word(1'b1, 16'd3, 16'd3, 16'd3, 16'd3, 4'd1, 4'd0);
		send_word(1'b1, 16'd3, 16'd3, 16'd3, 16'd3, 4'd0, 4'd1);
		send_word(1'b1, 16'd50, 16'd50, 16'd1, 16'd1, 4'd0, 4'd1);
		send_word(1'b1, 16'd4, 16'd4, 16'd46, 16'd46, 4'd0, 4'd1);
		send_word(1'b1, 16'd9, 16'd9, 16'd9, 16'd9, 4'd15, 4'd15);

		// random phases with register changes between them
		for (int p = 0; p < 8; p++) begin
			write_select(1'($urandom_range(1)));
			no_idle <= (p == 3);
			random_phase(100, 0);
		end
		no_idle <= 1'b0;

		// fill the store past its limit, then clear it
		write_select(1'b0);
		send_word(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
		random_phase(262, 1);
		send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
		send_word(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 4'd1, 4'd1);
		write_select(1'b1);
		send_word(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 4'd0, 4'd15);
		send_word(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
		random_phase(40, 0);
		in_ch.valid <= 1'b0;

		// drain, then let the block settle
		@(posedge clk);
		while (words_out != words_in) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("touching_rectangle_fragment_tracker: match");
		else
			$display("touching_rectangle_fragment_tracker: mismatch");
		$finish;
	end
endmodule
